// ----- rtl/core/ibd_pkg.sv -----
// Shared types and constants for the box-filter downsampler.
// Used by ibd_ctrl, ibd_dp and image_box_downsample; depends on nothing.
`default_nettype none

package ibd_pkg;

  // Fixed field and register widths
  localparam int PIX_W        = 8;
  localparam int MEAN_W       = 8;
  localparam int IDX_W        = 12;
  localparam int ROW_W        = 12;
  localparam int HGT_W        = 13;
  localparam int SUM_W        = 16;
  localparam int DIVD_W       = SUM_W + 1;
  localparam int FACTOR_REG_W = 5;
  localparam int DIM_REG_W    = 13;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int MAX_HEIGHT   = 4096;

  // Serial divider: one quotient bit per step
  localparam int DIV_STEPS = MEAN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register reset values
  localparam logic [FACTOR_REG_W-1:0] FACTOR_RST = 5'd2;
  localparam logic [DIM_REG_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_REG_W-1:0]    HEIGHT_RST = 13'd480;

  // Register indexes (word address bits)
  typedef enum logic [1:0] {
    REG_FACTOR = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic restart;
    logic step;
    logic acc;
    logic div_start;
    logic div_step;
    logic load;
  } ibd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic col_end;
    logic blk_end;
    logic div_last;
    logic out_free;
  } ibd_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ibd_ctrl.sv -----
// Sequencer for the downsampler: pixel step, column-sum update, divide, output load.
// Depends on ibd_pkg for the command and status structs.
`default_nettype none

module ibd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 cfg_wr,
  input  ibd_pkg::ibd_stat_t  st,
  output ibd_pkg::ibd_cmd_t   cmd,
  output logic                in_stall
);
  import ibd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   blk_pend_r, blk_pend_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    blk_pend_nxt = blk_pend_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.restart = cfg_wr;
        cmd.step    = in_valid;
        if (in_valid) begin
          blk_pend_nxt = st.blk_end;
          if (st.col_end) state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (blk_pend_r) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      blk_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      blk_pend_r <= blk_pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ibd_dp.sv -----
// Datapath: position counters, column-sum store, serial divider, output register.
// Depends on ibd_pkg; driven by ibd_ctrl commands.
`default_nettype none

module ibd_dp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  ibd_pkg::ibd_cmd_t                          cmd,
  output ibd_pkg::ibd_stat_t                         st,
  input  wire [$clog2(MAX_FACTOR+1)-1:0]             f_eff,
  input  wire [$clog2(MAX_WIDTH+1)-1:0]              w_eff,
  input  wire [ibd_pkg::HGT_W-1:0]                   h_eff,
  input  wire [ibd_pkg::PIX_W-1:0]                   in_pixel,
  input  wire                                        out_stall,
  output logic                                       out_valid,
  output logic [ibd_pkg::MEAN_W-1:0]                 out_mean_value,
  output logic [ibd_pkg::IDX_W-1:0]                  out_row,
  output logic [ibd_pkg::IDX_W-1:0]                  out_col,
  output logic                                       out_frame_last
);
  import ibd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int NW = 2 * FW;
  localparam int DW = NW + 1;

  // Position state
  logic [WW-1:0]    col_pos_r, col_start_r;
  logic [FW-1:0]    col_blk_r, row_blk_r;
  logic [AW-1:0]    oc_r;
  logic [ROW_W-1:0] row_pos_r, row_start_r;
  logic [IDX_W-1:0] orow_r;
  logic [SUM_W-1:0] run_sum_r;

  // Context held from a step for the column-sum update
  logic [SUM_W-1:0] rs_hold_r;
  logic             first_row_r;
  logic [AW-1:0]    addr_r;
  logic [IDX_W-1:0] hold_row_r, hold_col_r;
  logic             hold_last_r;

  // Column-sum store
  logic [SUM_W-1:0] col_sum_mem [MAX_WIDTH];
  logic [SUM_W-1:0] rd_data_r;

  // Divider
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W:0]   dsh_r;
  logic [DW-1:0]     d_r;
  logic [MEAN_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;

  // Output register
  logic              out_valid_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic              out_last_r;

  // Block fit tests against the frame edges
  logic [WW+1:0]    col_end_pos, col_next_end;
  logic [HGT_W:0]   row_end_pos, row_next_end;
  logic             col_fit, row_fit, in_range, col_last_blk, row_last_blk;
  logic [FW-1:0]    col_blk_inc, row_blk_inc;
  logic             col_wrap, row_wrap;
  logic [WW-1:0]    col_pos_inc;
  logic [HGT_W-1:0] row_pos_inc;
  logic             row_eol, frame_end;
  logic [SUM_W-1:0] rs, acc;
  logic [NW-1:0]    n;
  logic [DW-1:0]    d;
  logic             ge;

  always_comb begin
    col_end_pos  = (WW+2)'(col_start_r) + (WW+2)'(f_eff);
    col_next_end = col_end_pos + (WW+2)'(f_eff);
    col_fit      = col_end_pos <= (WW+2)'(w_eff);
    col_last_blk = col_next_end > (WW+2)'(w_eff);
    row_end_pos  = (HGT_W+1)'(row_start_r) + (HGT_W+1)'(f_eff);
    row_next_end = row_end_pos + (HGT_W+1)'(f_eff);
    row_fit      = row_end_pos <= (HGT_W+1)'(h_eff);
    row_last_blk = row_next_end > (HGT_W+1)'(h_eff);
    in_range     = col_fit && row_fit;
    col_blk_inc  = col_blk_r + 1'b1;
    row_blk_inc  = row_blk_r + 1'b1;
    col_wrap     = col_blk_inc >= f_eff;
    row_wrap     = row_blk_inc >= f_eff;
    col_pos_inc  = col_pos_r + 1'b1;
    row_pos_inc  = HGT_W'(row_pos_r) + 1'b1;
    row_eol      = col_pos_inc >= w_eff;
    frame_end    = row_pos_inc >= h_eff;
    rs           = ((col_blk_r == '0) ? '0 : run_sum_r) + SUM_W'(in_pixel);
    acc          = rs_hold_r + (first_row_r ? '0 : rd_data_r);
    n            = NW'(f_eff) * NW'(f_eff);
    d            = {n, 1'b0};
    ge           = (DIVD_W+1)'(rem_r) >= dsh_r;
  end

  assign st.col_end  = in_range && col_wrap;
  assign st.blk_end  = in_range && col_wrap && row_wrap;
  assign st.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign st.out_free = !out_valid_r || !out_stall;

  // Advance position counters and the running row-segment sum
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      col_pos_r   <= '0;
      col_start_r <= '0;
      col_blk_r   <= '0;
      oc_r        <= '0;
      row_pos_r   <= '0;
      row_start_r <= '0;
      row_blk_r   <= '0;
      orow_r      <= '0;
      run_sum_r   <= '0;
    end else if (cmd.step) begin
      if (in_range) run_sum_r <= col_wrap ? '0 : rs;
      if (row_eol) begin
        col_pos_r   <= '0;
        col_start_r <= '0;
        col_blk_r   <= '0;
        oc_r        <= '0;
        run_sum_r   <= '0;
        if (frame_end) begin
          row_pos_r   <= '0;
          row_start_r <= '0;
          row_blk_r   <= '0;
          orow_r      <= '0;
        end else begin
          row_pos_r <= ROW_W'(row_pos_inc);
          row_blk_r <= row_wrap ? '0 : row_blk_inc;
          if (row_wrap) begin
            orow_r      <= orow_r + 1'b1;
            row_start_r <= row_start_r + ROW_W'(f_eff);
          end
        end
      end else begin
        col_pos_r <= col_pos_inc;
        col_blk_r <= col_wrap ? '0 : col_blk_inc;
        if (col_wrap) begin
          oc_r        <= oc_r + 1'b1;
          col_start_r <= col_start_r + WW'(f_eff);
        end
      end
    end
  end

  // Hold step context for the column-sum update and the output word
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rs_hold_r   <= rs;
      first_row_r <= (row_blk_r == '0);
      addr_r      <= oc_r;
      hold_row_r  <= orow_r;
      hold_col_r  <= IDX_W'(oc_r);
      hold_last_r <= row_last_blk && col_last_blk;
    end
  end

  // Column-sum store: read on step, write back the block-row sum
  always_ff @(posedge clk) begin
    if (cmd.acc) col_sum_mem[addr_r] <= acc;
    if (cmd.step) rd_data_r <= col_sum_mem[oc_r];
  end

  // Restoring divider: floor((2*sum + n) / (2*n)), one quotient bit a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= {acc, 1'b0} + DIVD_W'(n);
      dsh_r <= (DIVD_W+1)'(d) << (DIV_STEPS - 1);
      d_r   <= d;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (ge) rem_r <= DIVD_W'((DIVD_W+1)'(rem_r) - dsh_r);
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[MEAN_W-2:0], ge};
    end
  end

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_mean_r <= q_r;
      out_row_r  <= hold_row_r;
      out_col_r  <= hold_col_r;
      out_last_r <= hold_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

  // Checks
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten before it was taken");

  a_acc_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> $past(cmd.step))
    else $error("column-sum update without a preceding pixel step");

  a_div_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> cmd.acc)
    else $error("divide started outside a column-sum update");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && st.div_last) |=> (rem_r < DIVD_W'(d_r)))
    else $error("divider remainder not below divisor at the end");

endmodule

`default_nettype wire

// ----- rtl/core/image_box_downsample.sv -----
// Box-filter downsampler: one output word per whole f x f block, rounded mean.
// The output word of a pixel that closes a block passes a column-sum read-modify-write, 8 divider
// steps and an output load; the load waits while the output register holds a word not yet taken.
// Throughput: 1 pixel per cycle; in_stall holds input after a pixel that ends a block column or a block.
// Reset (synchronous, rst_n low): counters zero, registers to defaults, output empty;
// the column-sum store is not cleared, the first row of each block writes it.
`default_nettype none

module image_box_downsample #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Pixel input
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [ibd_pkg::PIX_W-1:0]     in_pixel,
  // Result output
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [ibd_pkg::MEAN_W-1:0]   out_mean_value,
  output logic [ibd_pkg::IDX_W-1:0]    out_row,
  output logic [ibd_pkg::IDX_W-1:0]    out_col,
  output logic                         out_frame_last,
  // Register port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [ibd_pkg::APB_AW-1:0]    paddr,
  input  wire [ibd_pkg::APB_DW-1:0]    pwdata,
  output logic [ibd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import ibd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int FW = $clog2(MAX_FACTOR + 1);

  logic [FACTOR_REG_W-1:0] factor_r;
  logic [DIM_REG_W-1:0]    width_r, height_r;
  logic                    wr, cfg_wr;
  reg_idx_t                idx;
  logic [FW-1:0]           f_eff;
  logic [WW-1:0]           w_eff;
  logic [HGT_W-1:0]        h_eff;
  ibd_cmd_t                cmd;
  ibd_stat_t               st;

  // Register decode
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_wr = 1'b0;
    prdata = '0;
    unique case (idx)
      REG_FACTOR: begin
        cfg_wr = wr;
        prdata = APB_DW'(factor_r);
      end
      REG_WIDTH: begin
        cfg_wr = wr;
        prdata = APB_DW'(width_r);
      end
      REG_HEIGHT: begin
        cfg_wr = wr;
        prdata = APB_DW'(height_r);
      end
      default: begin
        cfg_wr = 1'b0;
        prdata = '0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (wr) begin
      case (idx)
        REG_FACTOR: factor_r <= pwdata[FACTOR_REG_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[DIM_REG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp register values to their working ranges
  always_comb begin
    if (factor_r == '0)                f_eff = FW'(1);
    else if (32'(factor_r) > MAX_FACTOR) f_eff = FW'(MAX_FACTOR);
    else                               f_eff = FW'(factor_r);
    if (width_r == '0)                 w_eff = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else                               w_eff = WW'(width_r);
    if (height_r == '0)                h_eff = HGT_W'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = HGT_W'(MAX_HEIGHT);
    else                               h_eff = height_r;
  end

  ibd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_wr   (cfg_wr),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  ibd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .f_eff          (f_eff),
    .w_eff          (w_eff),
    .h_eff          (h_eff),
    .in_pixel       (in_pixel),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_mean_value (out_mean_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire
